// ===== sv/rclfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rclfr_pkg
// Shared constants, codes and controller/datapath interface types for the
// RC link frame receiver.
// ----------------------------------------------------------------------------
package rclfr_pkg;

  localparam int BUFFER_BYTES  = 64;
  localparam int BUF_AW        = $clog2(BUFFER_BYTES);
  localparam int CHANNEL_COUNT = 16;
  localparam int CHANNEL_BITS  = 11;
  localparam int CHAN_W        = 4;
  localparam int VAL_W         = 11;
  localparam int TOTAL_W       = BUF_AW + 1;
  // bit accumulator: up to CHANNEL_BITS-1 leftover bits plus one byte
  localparam int ACC_W         = CHANNEL_BITS + 7;
  localparam int CNT_W         = $clog2(ACC_W + 1);
  localparam int OUT_DATA_W    = 48;

  localparam logic [7:0] TYPE_CHANNELS = 8'h16;
  localparam logic [7:0] TYPE_LINKSTAT = 8'h14;
  localparam logic [7:0] CRC_POLY      = 8'hD5;
  localparam logic [7:0] SYNC_RESET    = 8'hC8;
  localparam logic [5:0] MAXLEN_RESET  = 6'd62;
  localparam logic [7:0] LEN_LIMIT     = 8'(BUFFER_BYTES - 2);
  localparam logic [7:0] LEN_MIN       = 8'd2;

  localparam logic [BUF_AW-1:0] IDX_SYNC    = BUF_AW'(0);
  localparam logic [BUF_AW-1:0] IDX_LEN     = BUF_AW'(1);
  localparam logic [BUF_AW-1:0] IDX_TYPE    = BUF_AW'(2);
  localparam logic [BUF_AW-1:0] IDX_PAYLOAD = BUF_AW'(3);
  localparam logic [BUF_AW-1:0] IDX_RSSI    = BUF_AW'(3);
  localparam logic [BUF_AW-1:0] IDX_LQ      = BUF_AW'(5);
  localparam logic [BUF_AW-1:0] IDX_SNR     = BUF_AW'(6);

  // configuration register indexes
  localparam logic CFG_SYNC   = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;

  typedef enum logic [1:0] {
    ST_CHANNEL  = 2'd0,
    ST_LINKSTAT = 2'd1,
    ST_OTHER    = 2'd2,
    ST_CRC_ERR  = 2'd3
  } status_e;

  typedef struct packed {
    logic    sync_wr;
    logic    len_wr;
    logic    data_wr;
    logic    rd_init;
    logic    rd_en;
    logic    acc_push;
    logic    emit;
    status_e kind;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic len_ok;
    logic is_last;
    logic crc_ok;
    logic is_chan;
    logic is_ls;
    logic rd_ls_end;
    logic acc_ge;
    logic chan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/rclfr_ram.sv =====
// ----------------------------------------------------------------------------
// rclfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rclfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rclfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rclfr_ctrl
// Frame receiver sequencer: sync hunt, length check, byte collection, then
// the result drain for channel, link statistics, plain or CRC error frames.
// ----------------------------------------------------------------------------
module rclfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rclfr_pkg::sts_t sts_i,
  output rclfr_pkg::cmd_t cmd_o
);
  import rclfr_pkg::*;

  typedef enum logic [3:0] {
    S_HUNT,
    S_LEN,
    S_DATA,
    S_CHECK,
    S_CH_RD,
    S_CH_PUSH,
    S_CH_EMIT,
    S_LS_RD,
    S_LS_WAIT,
    S_EMIT_LS,
    S_EMIT_ERR,
    S_EMIT_OTHER
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;
  logic   ready;
  logic   acc;

  assign ready = (state_q == S_HUNT) || (state_q == S_LEN) || (state_q == S_DATA);
  assign acc   = in_valid_i && ready;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.kind = ST_OTHER;
    unique case (state_q)
      S_HUNT: begin
        if (acc && sts_i.is_sync) begin
          cmd.sync_wr = 1'b1;
          state_d     = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          if (sts_i.len_ok) begin
            cmd.len_wr = 1'b1;
            state_d    = S_DATA;
          end else begin
            state_d = S_HUNT;
          end
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.data_wr = 1'b1;
          if (sts_i.is_last) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.rd_init = 1'b1;
        if (!sts_i.crc_ok)      state_d = S_EMIT_ERR;
        else if (sts_i.is_chan) state_d = S_CH_RD;
        else if (sts_i.is_ls)   state_d = S_LS_RD;
        else                    state_d = S_EMIT_OTHER;
      end
      S_CH_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = S_CH_PUSH;
      end
      S_CH_PUSH: begin
        cmd.acc_push = 1'b1;
        state_d      = S_CH_EMIT;
      end
      S_CH_EMIT: begin
        if (!sts_i.acc_ge) begin
          state_d = S_CH_RD;
        end else if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ST_CHANNEL;
          cmd.last = sts_i.chan_last;
          if (sts_i.chan_last) state_d = S_HUNT;
        end
      end
      S_LS_RD: begin
        cmd.rd_en = 1'b1;
        if (sts_i.rd_ls_end) state_d = S_LS_WAIT;
      end
      S_LS_WAIT: begin
        state_d = S_EMIT_LS;
      end
      S_EMIT_LS: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ST_LINKSTAT;
          cmd.last = 1'b1;
          state_d  = S_HUNT;
        end
      end
      S_EMIT_ERR: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ST_CRC_ERR;
          cmd.last = 1'b1;
          state_d  = S_HUNT;
        end
      end
      S_EMIT_OTHER: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = ST_OTHER;
          cmd.last = 1'b1;
          state_d  = S_HUNT;
        end
      end
      default: state_d = S_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = ready;
  assign cmd_o      = cmd;

  // no input is taken while results drain
  a_no_rx_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !in_ready_o)
    else $error("input ready while emitting a result");

  // the check state, passing or failing, always leads into a read or an emit path
  a_check_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |=> !in_ready_o)
    else $error("check state returned to input without a result");

  // a frame is only closed by a write of its final byte
  a_close_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA && state_d == S_CHECK) |-> (cmd.data_wr && sts_i.is_last))
    else $error("frame closed without its last byte");

endmodule

// ===== sv/rclfr_dp.sv =====
// ----------------------------------------------------------------------------
// rclfr_dp
// Datapath: configuration registers, frame store with reset valid bits,
// running CRC-8, channel bit unpacker and the output register.
// ----------------------------------------------------------------------------
module rclfr_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   out_ready_i,
  input  rclfr_pkg::cmd_t        cmd_i,
  output rclfr_pkg::sts_t        sts_o,
  output logic                   out_valid_o,
  output rclfr_pkg::status_e     out_status_o,
  output logic [7:0]             out_type_o,
  output logic [rclfr_pkg::CHAN_W-1:0] out_chan_o,
  output logic [rclfr_pkg::VAL_W-1:0]  out_value_o,
  output logic [7:0]             out_rssi_o,
  output logic [7:0]             out_lq_o,
  output logic [7:0]             out_snr_o,
  output logic                   out_last_o
);
  import rclfr_pkg::*;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // configuration
  logic [7:0] sync_q;
  logic [5:0] maxlen_q;
  logic [7:0] limit;

  // frame collection
  logic [BUF_AW-1:0]  wr_idx_q;
  logic [TOTAL_W-1:0] total_q;
  logic [7:0]         crc_q, crc_byte_q, type_q;
  logic               wr_en;
  logic [BUF_AW-1:0]  wr_addr;
  logic               last_byte;

  // store reads
  logic [BUFFER_BYTES-1:0] valid_q;
  logic [BUF_AW-1:0]       rd_addr_q, rd_tag_q;
  logic                    rd_vld_q, vbit_q;
  logic [7:0]              ram_rdata, rd_byte;
  logic [7:0]              rssi_q, lq_q, snr_q;

  // channel unpacker
  logic [ACC_W-1:0]  acc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CHAN_W-1:0] chan_q;

  // output register
  logic              out_vld_q;
  status_e           o_status_q;
  logic [7:0]        o_type_q, o_rssi_q, o_lq_q, o_snr_q;
  logic [CHAN_W-1:0] o_chan_q;
  logic [VAL_W-1:0]  o_value_q;
  logic              o_last_q;
  logic              out_free;
  logic              chan_emit, ls_emit;

  assign limit     = ({2'b00, maxlen_q} > LEN_LIMIT) ? LEN_LIMIT : {2'b00, maxlen_q};
  assign wr_en     = cmd_i.sync_wr || cmd_i.len_wr || cmd_i.data_wr;
  assign wr_addr   = cmd_i.sync_wr ? IDX_SYNC : (cmd_i.len_wr ? IDX_LEN : wr_idx_q);
  assign last_byte = ({1'b0, wr_idx_q} + TOTAL_W'(1)) == total_q;
  assign rd_byte   = vbit_q ? ram_rdata : 8'h00;
  assign out_free  = !out_vld_q || out_ready_i;
  assign chan_emit = cmd_i.emit && (cmd_i.kind == ST_CHANNEL);
  assign ls_emit   = cmd_i.emit && (cmd_i.kind == ST_LINKSTAT);

  rclfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sts_o.is_sync   = rx_byte_i == sync_q;
    sts_o.len_ok    = (rx_byte_i >= LEN_MIN) && (rx_byte_i <= limit);
    sts_o.is_last   = last_byte;
    sts_o.crc_ok    = crc_q == crc_byte_q;
    sts_o.is_chan   = type_q == TYPE_CHANNELS;
    sts_o.is_ls     = type_q == TYPE_LINKSTAT;
    sts_o.rd_ls_end = rd_addr_q == IDX_SNR;
    sts_o.acc_ge    = cnt_q >= CNT_W'(CHANNEL_BITS);
    sts_o.chan_last = chan_q == CHAN_W'(CHANNEL_COUNT - 1);
    sts_o.out_free  = out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q    <= SYNC_RESET;
      maxlen_q  <= MAXLEN_RESET;
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SYNC:   sync_q   <= cfg_wdata_i;
          CFG_MAXLEN: maxlen_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.emit)       out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.sync_wr) begin
      wr_idx_q <= IDX_LEN;
      crc_q    <= 8'h00;
    end
    if (cmd_i.len_wr) begin
      wr_idx_q <= IDX_TYPE;
      total_q  <= TOTAL_W'(rx_byte_i) + TOTAL_W'(2);
    end
    if (cmd_i.data_wr) begin
      wr_idx_q <= wr_idx_q + BUF_AW'(1);
      if (wr_idx_q == IDX_TYPE) type_q <= rx_byte_i;
      if (last_byte) crc_byte_q <= rx_byte_i;
      else           crc_q      <= crc8_step(crc_q, rx_byte_i);
    end

    if (cmd_i.rd_init) begin
      rd_addr_q <= IDX_PAYLOAD;
      acc_q     <= '0;
      cnt_q     <= '0;
      chan_q    <= '0;
    end
    if (cmd_i.rd_en) begin
      rd_addr_q <= rd_addr_q + BUF_AW'(1);
      rd_tag_q  <= rd_addr_q;
      vbit_q    <= valid_q[rd_addr_q];
    end
    if (rd_vld_q) begin
      if (rd_tag_q == IDX_RSSI) rssi_q <= rd_byte;
      if (rd_tag_q == IDX_LQ)   lq_q   <= rd_byte;
      if (rd_tag_q == IDX_SNR)  snr_q  <= rd_byte;
    end
    if (cmd_i.acc_push) begin
      acc_q <= acc_q | ({{(ACC_W-8){1'b0}}, rd_byte} << cnt_q);
      cnt_q <= cnt_q + CNT_W'(8);
    end

    if (cmd_i.emit) begin
      o_status_q <= cmd_i.kind;
      o_type_q   <= type_q;
      o_last_q   <= cmd_i.last;
      o_chan_q   <= chan_emit ? chan_q : '0;
      o_value_q  <= chan_emit ? acc_q[VAL_W-1:0] : '0;
      o_rssi_q   <= ls_emit ? rssi_q : 8'h00;
      o_lq_q     <= ls_emit ? lq_q : 8'h00;
      o_snr_q    <= ls_emit ? snr_q : 8'h00;
      if (chan_emit) begin
        acc_q  <= acc_q >> CHANNEL_BITS;
        cnt_q  <= cnt_q - CNT_W'(CHANNEL_BITS);
        chan_q <= chan_q + CHAN_W'(1);
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = o_status_q;
  assign out_type_o   = o_type_q;
  assign out_chan_o   = o_chan_q;
  assign out_value_o  = o_value_q;
  assign out_rssi_o   = o_rssi_q;
  assign out_lq_o     = o_lq_q;
  assign out_snr_o    = o_snr_q;
  assign out_last_o   = o_last_q;

  // a channel is only cut from the accumulator once enough bits are in
  a_chan_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.kind == ST_CHANNEL) |-> (cnt_q >= CNT_W'(CHANNEL_BITS)))
    else $error("channel emitted from a short accumulator");

  // store is never written and read in the same cycle
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && cmd_i.rd_en))
    else $error("frame store written during a drain read");

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result register overwritten");

  // accumulator never overflows its width
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_push |-> (cnt_q < CNT_W'(CHANNEL_BITS)))
    else $error("byte pushed into a full accumulator");

endmodule

// ===== sv/rc_link_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// rc_link_frame_receiver_core
// RC link frame receiver: sync hunt, length check, CRC-8 (poly 0xD5) and
// channel / link statistics result generation.
// ----------------------------------------------------------------------------
// Serial bytes are taken one per cycle while a frame is hunted for and
// collected. After the closing CRC byte the block stops taking bytes while it
// drains that frame's results: a CRC error or plain frame passes the check
// state and gives one result, a link statistics frame first makes four frame
// store reads, a channel frame reads the 22 payload bytes from the single
// store port by a read and a push state each and gives a channel result
// whenever enough bits are in; each result waits while the result side stalls.
// The frame store needs no clearing pass: per-entry valid bits cleared at
// reset make unwritten entries read as zero.
module rc_link_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] frame_type, [11:8] channel_index, [22:12] channel_value,
  // [30:23] rssi, [38:31] link_quality, [46:39] snr, [47] zero
  output logic [rclfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);
  import rclfr_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  status_e           out_status;
  logic [7:0]        out_type, out_rssi, out_lq, out_snr;
  logic [CHAN_W-1:0] out_chan;
  logic [VAL_W-1:0]  out_value;

  rclfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rclfr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_byte_i    (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_type_o   (out_type),
    .out_chan_o   (out_chan),
    .out_value_o  (out_value),
    .out_rssi_o   (out_rssi),
    .out_lq_o     (out_lq),
    .out_snr_o    (out_snr),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_snr, out_lq, out_rssi, out_value, out_chan, out_type};
  assign m_axis_tuser = out_status;

endmodule
